>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while out of reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed on queue ports");

// Implication whose effect is checked in the cycle after the cause.
`define ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cause) |=> (effect)) else $error("assertion failed on queue ports");

`endif

>>> sv/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Sizes, codes and types shared by the sorted priority queue chain.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int Depth   = 16;
  localparam int CountW  = $clog2(Depth + 1);
  localparam int ValueW  = 32;
  localparam int PrioW   = 16;
  localparam int StatusW = 2;
  localparam int FillW   = 5;

  localparam logic CmdEnq = 1'b0;
  localparam logic CmdDeq = 1'b1;

  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusOverflow  = 2'd1;
  localparam logic [StatusW-1:0] StatusUnderflow = 2'd2;

  // Contents of one chain slot.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
  } smpq_slot_t;

  // Operation broadcast to every slot in the cycle of acceptance.
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
  } smpq_op_t;

endpackage

>>> sv/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
module smpq_cell import smpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  smpq_op_t   op_i,
  input  smpq_slot_t left_i,
  input  logic       left_gt_i,
  input  smpq_slot_t right_i,
  output smpq_slot_t slot_o,
  output logic       gt_o
);

  smpq_slot_t slot_q, slot_d;

  // True when the new entry belongs at or before this slot. Equal priorities
  // compare false, so a newcomer lands behind older entries of its priority.
  assign gt_o = !slot_q.valid || ($signed(slot_q.prio) > $signed(op_i.prio));

  always_comb begin
    slot_d = slot_q;
    priority if (op_i.enq && gt_o) begin
      if (left_gt_i) begin
        slot_d = left_i;
      end else begin
        slot_d = '{valid: 1'b1, value: op_i.value, prio: op_i.prio};
      end
    end else if (op_i.deq) begin
      slot_d = right_i;
    end else begin
      slot_d = slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

>>> sv/stable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Output: the result beat is registered and appears in the cycle after the operation is accepted.
// Throughput: one operation per cycle; every slot of the chain updates at once.
// A waiting result stalls input only when it is not taken in the same cycle.
// Reset clears all slot valid bits and the count; the queue starts empty.
// ----------------------------------------------------------------------------
module stable_min_priority_queue import smpq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     cmd_i,
  input  logic signed [ValueW-1:0] item_value_i,
  input  logic signed [PrioW-1:0]  item_priority_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [StatusW-1:0]       status_o,
  output logic signed [ValueW-1:0] out_value_o,
  output logic signed [PrioW-1:0]  out_priority_o,
  output logic [FillW-1:0]         fill_count_o
);

  smpq_op_t   op;
  smpq_slot_t slots [Depth];
  logic       gts   [Depth];

  logic [CountW-1:0] count_q, count_d;
  logic              accept, full, empty;

  logic                out_valid_q;
  logic [StatusW-1:0]  status_q, status_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic [PrioW-1:0]    prio_q, prio_d;
  logic [FillW-1:0]    fill_q;
  logic [CountW+FillW-1:0] count_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CountW'(Depth));
  assign empty      = (count_q == '0);

  assign op.enq   = accept && (cmd_i == CmdEnq) && !full;
  assign op.deq   = accept && (cmd_i == CmdDeq) && !empty;
  assign op.value = item_value_i;
  assign op.prio  = item_priority_i;

  for (genvar i = 0; i < Depth; i++) begin : g_chain
    smpq_slot_t left, right;
    logic       left_gt;

    if (i == 0) begin : g_head
      assign left    = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left    = slots[i-1];
      assign left_gt = gts[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = slots[i+1];
    end

    smpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .left_i    (left),
      .left_gt_i (left_gt),
      .right_i   (right),
      .slot_o    (slots[i]),
      .gt_o      (gts[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = StatusOk;
    value_d  = '0;
    prio_d   = '0;
    unique case (cmd_i)
      CmdEnq: begin
        if (full) begin
          status_d = StatusOverflow;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      CmdDeq: begin
        if (empty) begin
          status_d = StatusUnderflow;
        end else begin
          count_d = count_q - CountW'(1);
          value_d = slots[0].value;
          prio_d  = slots[0].prio;
        end
      end
      default: begin
        status_d = StatusOk;
      end
    endcase
  end

  // The fill field shows the count after the operation; FillW bits hold it whole.
  assign count_ext = {{FillW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      prio_q   <= prio_d;
      fill_q   <= count_ext[FillW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_value_o    = value_q;
  assign out_priority_o = prio_q;
  assign fill_count_o   = fill_q;

endmodule

>>> sv/smpq_checker.sv
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smpq_checker import smpq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [StatusW-1:0] status_o,
  input logic [ValueW-1:0]  out_value_o,
  input logic [PrioW-1:0]   out_priority_o,
  input logic [FillW-1:0]   fill_count_o
);

  logic no_entry;
  logic underflow_beat;
  logic overflow_beat;

  assign no_entry       = (out_value_o == '0) && (out_priority_o == '0);
  assign underflow_beat = out_valid_o && (status_o == StatusUnderflow);
  assign overflow_beat  = out_valid_o && (status_o == StatusOverflow);

  // A result beat is not withdrawn before it is taken.
  `ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // Every accepted operation produces a result beat in the next cycle.
  `ASSERT_NEXT(a_in_to_out, in_valid_i && in_ready_o, out_valid_o)

  // An underflow happens only on an empty queue and returns no entry.
  `ASSERT_CLK(a_underflow, !underflow_beat || (no_entry && fill_count_o == '0))

  // An overflow happens only on a full queue and returns no entry.
  `ASSERT_CLK(a_overflow, !overflow_beat || (no_entry && fill_count_o == FillW'(Depth)))

endmodule

bind stable_min_priority_queue smpq_checker u_smpq_checker (.*);
